// ===== rtl/pid_speed_update_assert.svh =====
// assertion macros for the pid speed update block
// no dependencies; taken in by the modules that check their own logic
`ifndef PID_SPEED_UPDATE_ASSERT_SVH
`define PID_SPEED_UPDATE_ASSERT_SVH
`ifndef SYNTHESIS
`define PIDSU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pid_speed_update: assertion failed");
`define PIDSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pid_speed_update: assertion failed");
`else
`define PIDSU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PIDSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/pidsu_pkg.sv =====
// shared constants, types and helpers of the pid speed update block
// no dependencies; imported by every module of the block
package pidsu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;
  localparam int MAG_W     = DATA_W + CFG_W;
  localparam int PROD_W    = MAG_W - FRAC_BITS;
  localparam int ACC_W     = 64;
  localparam int DIV_STEPS = CFG_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int DIV_W     = DATA_W + 1 + FRAC_BITS;
  localparam int DIV_HI_W  = DIV_W - DIV_STEPS;

  localparam longint ONE_Q = longint'(1) << FRAC_BITS;

  localparam logic [CFG_W-1:0] PROP_GAIN_RST  = CFG_W'((ONE_Q * 4 + 5) / 10);
  localparam logic [CFG_W-1:0] INTEG_GAIN_RST = CFG_W'((ONE_Q + 5) / 10);
  localparam logic [CFG_W-1:0] DERIV_GAIN_RST = CFG_W'((ONE_Q + 10) / 20);
  localparam logic [CFG_W-1:0] STEP_TIME_RST  = CFG_W'(ONE_Q);

  localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN  = 2'd0,
    CFG_INTEG_GAIN = 2'd1,
    CFG_DERIV_GAIN = 2'd2,
    CFG_STEP_TIME  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MUL_ERR_DT,
    MUL_KP_ERR,
    MUL_KI_INTEG,
    MUL_KD_DERIV,
    MUL_DRIVE_DT
  } mul_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_ED,
    S_INTEG,
    S_MUL_KI,
    S_ACC_KI,
    S_DIV_WAIT,
    S_MUL_KD,
    S_DRIVE,
    S_MUL_DT,
    S_SPEED
  } state_e;

  typedef struct packed {
    logic     ld_err;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     ld_integ;
    logic     div_start;
    logic     acc_clr;
    logic     acc_add;
    logic     ld_drive;
    logic     ld_speed;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_busy;
  } sts_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-DATA_W:0] top;
    top = v[ACC_W-1:DATA_W-1];
    if ((&top) || (~|top)) begin
      return v[DATA_W-1:0];
    end
    return v[ACC_W-1] ? S32_MIN : S32_MAX;
  endfunction

  function automatic logic signed [ACC_W-1:0] sext64(input logic signed [DATA_W-1:0] v);
    return {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

endpackage

// ===== rtl/pidsu_div.sv =====
// bit-serial restoring divider for the derivative term, one quotient bit a cycle
// depends on pidsu_pkg and the assertion header
`include "pid_speed_update_assert.svh"
module pidsu_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [pidsu_pkg::DATA_W:0]   diff_i,
  input  logic [pidsu_pkg::CFG_W-1:0]         divisor_i,
  output logic                                busy_o,
  output logic signed [pidsu_pkg::DATA_W-1:0] quot_o
);
  import pidsu_pkg::*;

  logic                       busy_q, busy_d;
  logic [DIV_CNT_W-1:0]       cnt_q, cnt_d;
  logic                       neg_q, neg_d;
  logic                       ovf_q, ovf_d;
  logic [CFG_W-1:0]           rem_q, rem_d;
  logic [DIV_STEPS-1:0]       dq_q, dq_d;
  logic signed [DATA_W-1:0]   quot_q, quot_d;

  logic                       diff_neg;
  logic [DATA_W:0]            diff_mag;
  logic [DIV_W-1:0]           num;
  logic [CFG_W-1:0]           num_hi;
  logic                       num_ovf;
  logic [CFG_W:0]             shifted;
  logic [CFG_W+1:0]           trial;
  logic                       fits;
  logic [DIV_STEPS-1:0]       dq_step;
  logic [DATA_W-1:0]          q_ext;
  logic                       last_step;

  assign diff_neg = diff_i[DATA_W];
  assign diff_mag = diff_neg ? (~diff_i + 1'b1) : diff_i;
  assign num      = {diff_mag, {FRAC_BITS{1'b0}}};
  assign num_hi   = {{(CFG_W-DIV_HI_W){1'b0}}, num[DIV_W-1:DIV_STEPS]};
  // quotient at or above 2^31 saturates
  assign num_ovf  = num_hi >= divisor_i;

  assign shifted   = {rem_q, dq_q[DIV_STEPS-1]};
  assign trial     = {1'b0, shifted} - {2'b00, divisor_i};
  assign fits      = ~trial[CFG_W+1];
  assign dq_step   = {dq_q[DIV_STEPS-2:0], fits};
  assign q_ext     = {{(DATA_W-DIV_STEPS){1'b0}}, dq_step};
  assign last_step = cnt_q == DIV_CNT_W'(DIV_STEPS - 1);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    ovf_d  = ovf_q;
    rem_d  = rem_q;
    dq_d   = dq_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = diff_neg;
      ovf_d  = num_ovf;
      rem_d  = num_hi;
      dq_d   = num[DIV_STEPS-1:0];
    end else if (busy_q) begin
      rem_d = fits ? trial[CFG_W-1:0] : shifted[CFG_W-1:0];
      dq_d  = dq_step;
      cnt_d = cnt_q + 1'b1;
      if (last_step) begin
        busy_d = 1'b0;
        if (ovf_q) begin
          quot_d = neg_q ? S32_MIN : S32_MAX;
        end else begin
          quot_d = neg_q ? (~q_ext + 1'b1) : q_ext;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
      ovf_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      neg_q  <= neg_d;
      ovf_q  <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dq_q   <= dq_d;
    quot_q <= quot_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

  `PIDSU_ASSERT_IMP(a_ovf_saturates, clk_i, rst_ni, !busy_q && ovf_q, quot_q == S32_MIN || quot_q == S32_MAX)

endmodule

// ===== rtl/pidsu_dpath.sv =====
// datapath: state registers, shared multiplier, accumulator and output register
// depends on pidsu_pkg and pidsu_div
module pidsu_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pidsu_pkg::cmd_t                     cmd_i,
  output pidsu_pkg::sts_t                     sts_o,
  input  logic signed [pidsu_pkg::DATA_W-1:0] target_speed_i,
  input  logic [pidsu_pkg::CFG_W-1:0]         prop_gain_i,
  input  logic [pidsu_pkg::CFG_W-1:0]         integ_gain_i,
  input  logic [pidsu_pkg::CFG_W-1:0]         deriv_gain_i,
  input  logic [pidsu_pkg::CFG_W-1:0]         step_time_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic signed [pidsu_pkg::DATA_W-1:0] speed_error_o,
  output logic signed [pidsu_pkg::DATA_W-1:0] drive_value_o,
  output logic signed [pidsu_pkg::DATA_W-1:0] new_speed_o
);
  import pidsu_pkg::*;

  logic signed [DATA_W-1:0] err_q, err_d;
  logic signed [DATA_W-1:0] last_q;
  logic signed [DATA_W-1:0] integ_q, integ_d;
  logic signed [DATA_W-1:0] speed_q, speed_d;
  logic signed [DATA_W-1:0] drive_q, drive_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic [PROD_W-1:0]        prod_mag_q, prod_mag_d;
  logic                     prod_neg_q, prod_neg_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] out_err_q, out_drive_q, out_speed_q;

  logic signed [DATA_W-1:0] a_op;
  logic [CFG_W-1:0]         b_op;
  logic [DATA_W-1:0]        a_mag;
  logic [MAG_W-1:0]         full;
  logic [ACC_W-1:0]         prod_ext;
  logic signed [ACC_W-1:0]  prod_s;
  logic signed [DATA_W:0]   diff;
  logic                     div_busy;
  logic signed [DATA_W-1:0] deriv;

  assign err_d = sat32(sext64(target_speed_i) - sext64(speed_q));
  assign diff  = {err_q[DATA_W-1], err_q} - {last_q[DATA_W-1], last_q};

  pidsu_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .diff_i    (diff),
    .divisor_i (step_time_i),
    .busy_o    (div_busy),
    .quot_o    (deriv)
  );

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_ERR_DT: begin
        a_op = err_q;
        b_op = step_time_i;
      end
      MUL_KP_ERR: begin
        a_op = err_q;
        b_op = prop_gain_i;
      end
      MUL_KI_INTEG: begin
        a_op = integ_q;
        b_op = integ_gain_i;
      end
      MUL_KD_DERIV: begin
        a_op = deriv;
        b_op = deriv_gain_i;
      end
      MUL_DRIVE_DT: begin
        a_op = drive_q;
        b_op = step_time_i;
      end
      default: begin
        a_op = err_q;
        b_op = step_time_i;
      end
    endcase
  end

  // sign and magnitude so that the shift truncates toward zero
  assign a_mag      = a_op[DATA_W-1] ? (~a_op + 1'b1) : a_op;
  assign full       = MAG_W'(a_mag) * MAG_W'(b_op);
  assign prod_mag_d = cmd_i.mul_en ? full[MAG_W-1:FRAC_BITS] : prod_mag_q;
  assign prod_neg_d = cmd_i.mul_en ? a_op[DATA_W-1] : prod_neg_q;

  assign prod_ext = {{(ACC_W-PROD_W){1'b0}}, prod_mag_q};
  assign prod_s   = prod_neg_q ? -$signed(prod_ext) : $signed(prod_ext);

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.acc_clr) begin
      acc_d = prod_s;
    end else if (cmd_i.acc_add) begin
      acc_d = acc_q + prod_s;
    end
  end

  assign integ_d = sat32(sext64(integ_q) + prod_s);
  assign drive_d = sat32(acc_q + prod_s);
  assign speed_d = sat32(sext64(speed_q) + prod_s);

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.ld_speed) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      integ_q     <= '0;
      speed_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.ld_integ) begin
        integ_q <= integ_d;
      end
      if (cmd_i.ld_speed) begin
        speed_q <= speed_d;
        last_q  <= err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_mag_q <= prod_mag_d;
    prod_neg_q <= prod_neg_d;
    acc_q      <= acc_d;
    if (cmd_i.ld_err) begin
      err_q <= err_d;
    end
    if (cmd_i.ld_drive) begin
      drive_q <= drive_d;
    end
    if (cmd_i.ld_speed) begin
      out_err_q   <= err_q;
      out_drive_q <= drive_q;
      out_speed_q <= speed_d;
    end
  end

  assign sts_o.div_busy = div_busy;
  assign sts_o.out_busy = out_valid_q & ~out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign speed_error_o = out_err_q;
  assign drive_value_o = out_drive_q;
  assign new_speed_o   = out_speed_q;

endmodule

// ===== rtl/pidsu_ctrl.sv =====
// controller: sequences one update through the datapath
// depends on pidsu_pkg and the assertion header
`include "pid_speed_update_assert.svh"
module pidsu_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pidsu_pkg::sts_t sts_i,
  output pidsu_pkg::cmd_t cmd_o
);
  import pidsu_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.mul_sel = MUL_ERR_DT;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_err = 1'b1;
          state_d      = S_MUL_ED;
        end
      end
      S_MUL_ED: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_ERR_DT;
        state_d       = S_INTEG;
      end
      S_INTEG: begin
        cmd_o.ld_integ  = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MUL_KP_ERR;
        state_d         = S_MUL_KI;
      end
      S_MUL_KI: begin
        cmd_o.acc_clr = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_KI_INTEG;
        state_d       = S_ACC_KI;
      end
      S_ACC_KI: begin
        cmd_o.acc_add = 1'b1;
        state_d       = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = S_MUL_KD;
        end
      end
      S_MUL_KD: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_KD_DERIV;
        state_d       = S_DRIVE;
      end
      S_DRIVE: begin
        cmd_o.ld_drive = 1'b1;
        state_d        = S_MUL_DT;
      end
      S_MUL_DT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DRIVE_DT;
        state_d       = S_SPEED;
      end
      S_SPEED: begin
        if (!sts_i.out_busy) begin
          cmd_o.ld_speed = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `PIDSU_ASSERT_IMP(a_div_start_free, clk_i, rst_ni, cmd_o.div_start, !sts_i.div_busy)
  `PIDSU_ASSERT_IMP(a_out_not_overwritten, clk_i, rst_ni, cmd_o.ld_speed, !sts_i.out_busy)
  `PIDSU_ASSERT_NEXT(a_accept_starts_update, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

endmodule

// ===== rtl/pid_speed_update.sv =====
// pid speed update: takes one input transaction at a time, none while an update is in progress;
// each update waits on the 31-step bit-serial divider of the derivative term;
// the multiplier is shared and its product is registered
// the result register lets the next input in while a result waits
// async active-low reset: gains and step time to defaults, speed, last error, integral to zero
module pid_speed_update (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pidsu_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pidsu_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [pidsu_pkg::DATA_W-1:0] target_speed_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [pidsu_pkg::DATA_W-1:0] speed_error_o,
  output logic signed [pidsu_pkg::DATA_W-1:0] drive_value_o,
  output logic signed [pidsu_pkg::DATA_W-1:0] new_speed_o
);
  import pidsu_pkg::*;

  logic [CFG_W-1:0] prop_gain_q, prop_gain_d;
  logic [CFG_W-1:0] integ_gain_q, integ_gain_d;
  logic [CFG_W-1:0] deriv_gain_q, deriv_gain_d;
  logic [CFG_W-1:0] step_time_q, step_time_d;
  cmd_t             cmd;
  sts_t             sts;

  // zero writes are refused
  always_comb begin
    prop_gain_d  = prop_gain_q;
    integ_gain_d = integ_gain_q;
    deriv_gain_d = deriv_gain_q;
    step_time_d  = step_time_q;
    if (cfg_we_i && (cfg_data_i != '0)) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PROP_GAIN:  prop_gain_d  = cfg_data_i;
        CFG_INTEG_GAIN: integ_gain_d = cfg_data_i;
        CFG_DERIV_GAIN: deriv_gain_d = cfg_data_i;
        CFG_STEP_TIME:  step_time_d  = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= PROP_GAIN_RST;
      integ_gain_q <= INTEG_GAIN_RST;
      deriv_gain_q <= DERIV_GAIN_RST;
      step_time_q  <= STEP_TIME_RST;
    end else begin
      prop_gain_q  <= prop_gain_d;
      integ_gain_q <= integ_gain_d;
      deriv_gain_q <= deriv_gain_d;
      step_time_q  <= step_time_d;
    end
  end

  pidsu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pidsu_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .target_speed_i (target_speed_i),
    .prop_gain_i    (prop_gain_q),
    .integ_gain_i   (integ_gain_q),
    .deriv_gain_i   (deriv_gain_q),
    .step_time_i    (step_time_q),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .speed_error_o  (speed_error_o),
    .drive_value_o  (drive_value_o),
    .new_speed_o    (new_speed_o)
  );

endmodule

// ===== bench/tb_top.sv =====
// self-checking testbench of pid_speed_update: predicts each speed update in fixed point
// and compares error, drive and new speed of every result transaction in order
// depends on rtl/pidsu_pkg.sv and rtl/pid_speed_update.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pidsu_pkg::*;

  localparam int          FB           = FRAC_BITS;
  localparam longint      Q_MAX        = 64'sd2147483647;
  localparam longint      Q_MIN        = -64'sd2147483648;
  localparam int unsigned LIMIT        = 500000;
  localparam int          DRAIN_CYCLES = 60;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          MAX_REPORTS  = 10;
  localparam logic [CFG_W-1:0] GAIN_MAX = {CFG_W{1'b1}};

  typedef struct packed {
    logic signed [DATA_W-1:0] err;
    logic signed [DATA_W-1:0] drive;
    logic signed [DATA_W-1:0] speed;
  } update_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_W-1:0]     cfg_idx_i;
  logic [CFG_W-1:0]         cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [DATA_W-1:0] target_speed_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [DATA_W-1:0] speed_error_o;
  logic signed [DATA_W-1:0] drive_value_o;
  logic signed [DATA_W-1:0] new_speed_o;

  // predictor state and register copies
  longint           spd_m   = 0;
  longint           lerr_m  = 0;
  longint           integ_m = 0;
  logic [CFG_W-1:0] kp_m    = CFG_W'(((longint'(1) << FB) * 4 + 5) / 10);
  logic [CFG_W-1:0] ki_m    = CFG_W'(((longint'(1) << FB) + 5) / 10);
  logic [CFG_W-1:0] kd_m    = CFG_W'(((longint'(1) << FB) + 10) / 20);
  logic [CFG_W-1:0] dt_m    = CFG_W'(longint'(1) << FB);

  update_t     update_q[$];
  int          err_cnt     = 0;
  int unsigned cycle_cnt   = 0;
  bit          tx_idle_en  = 1'b1;
  bit          rx_stall_en = 1'b1;
  int          rx_hold_len = 0;

  always #6 clk_i = ~clk_i;

  pid_speed_update u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .target_speed_i (target_speed_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .speed_error_o  (speed_error_o),
    .drive_value_o  (drive_value_o),
    .new_speed_o    (new_speed_o)
  );

  function automatic longint clamp_q(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    logic [63:0] ma, mb, p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p  = (ma * mb) >> FB;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint fx_div(input longint a, input longint b);
    logic [63:0] ma, mb, q;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    if (mb == 0) return 0;
    q = (ma << FB) / mb;
    return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic update_t pid_predict(input logic signed [DATA_W-1:0] tgt);
    longint  e, d, drv, dt;
    update_t r;
    dt      = longint'(dt_m);
    e       = clamp_q(longint'(tgt) - spd_m);
    integ_m = clamp_q(integ_m + fx_mul(e, dt));
    d       = clamp_q(fx_div(e - lerr_m, dt));
    // gain terms summed at full width, saturated once
    drv     = clamp_q(fx_mul(longint'(kp_m), e) + fx_mul(longint'(kd_m), d)
                      + fx_mul(longint'(ki_m), integ_m));
    spd_m   = clamp_q(spd_m + fx_mul(drv, dt));
    lerr_m  = e;
    r.err   = e[DATA_W-1:0];
    r.drive = drv[DATA_W-1:0];
    r.speed = spd_m[DATA_W-1:0];
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] rand_gain();
    case ($urandom_range(0, 6))
      0:       return CFG_W'($urandom());
      1:       return CFG_W'(1);
      2:       return GAIN_MAX;
      3:       return '0;
      default: return CFG_W'($urandom_range(1, 1 << (FB + 1)));
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_target();
    case ($urandom_range(0, 7))
      0:       return S32_MAX;
      1:       return S32_MIN;
      2, 3:    return DATA_W'($urandom());
      default: return DATA_W'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  task automatic check_field(input string name, input logic signed [DATA_W-1:0] want,
                             input logic signed [DATA_W-1:0] got);
    if (want !== got) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS) begin
        $display("mismatch %s: expected %0d, got %0d", name, want, got);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (update_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    // zero writes are refused
    if (val != '0) begin
      case (idx)
        CFG_PROP_GAIN:  kp_m = val;
        CFG_INTEG_GAIN: ki_m = val;
        CFG_DERIV_GAIN: kd_m = val;
        CFG_STEP_TIME:  dt_m = val;
        default: ;
      endcase
    end
  endtask

  task automatic set_gains(input logic [CFG_W-1:0] kp, input logic [CFG_W-1:0] ki,
                           input logic [CFG_W-1:0] kd, input logic [CFG_W-1:0] dt);
    wait_drained();
    write_reg(CFG_PROP_GAIN, kp);
    write_reg(CFG_INTEG_GAIN, ki);
    write_reg(CFG_DERIV_GAIN, kd);
    write_reg(CFG_STEP_TIME, dt);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_target(input logic signed [DATA_W-1:0] tgt);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    target_speed_i <= tgt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    update_q.push_back(pid_predict(tgt));
  endtask

  task automatic test_default_gains();
    send_target('0);
    send_target(S32_MAX);
    send_target(S32_MAX);
    send_target(S32_MIN);
    send_target(S32_MIN);
    send_target(DATA_W'(1));
    send_target(-DATA_W'(1));
    send_target(DATA_W'(1 << FB));
  endtask

  task automatic test_refused_writes();
    set_gains('0, '0, '0, '0);
    send_target(S32_MAX);
    send_target('0);
    send_target(-DATA_W'(1 << FB));
  endtask

  task automatic test_gain_extremes();
    set_gains(CFG_W'(1), CFG_W'(1), CFG_W'(1), CFG_W'(1));
    send_target(S32_MAX);
    send_target(S32_MIN);
    send_target('0);
    send_target(DATA_W'(12345));
    set_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
    send_target(S32_MAX);
    send_target(S32_MIN);
    send_target(DATA_W'(1));
    send_target(-DATA_W'(1));
    send_target('0);
    // huge derivative from a tiny step time
    set_gains(GAIN_MAX, CFG_W'(1), GAIN_MAX, CFG_W'(1));
    send_target(S32_MIN);
    send_target(S32_MAX);
    send_target('0);
    send_target(DATA_W'(100));
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 10; phase++) begin
      set_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain());
      repeat (40) send_target(rand_target());
    end
  endtask

  task automatic test_output_stall();
    set_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain());
    tx_idle_en  = 1'b0;
    rx_hold_len = HOLD_CYCLES;
    repeat (20) send_target(rand_target());
    tx_idle_en = 1'b1;
    // sender pause until every result is back
    wait_drained();
    repeat (10) send_target(rand_target());
  endtask

  task automatic test_full_rate();
    set_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain());
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    repeat (90) send_target(rand_target());
  endtask

  initial begin : receiver
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_len != 0) begin
        out_ready_i <= 1'b0;
        repeat (rx_hold_len) @(posedge clk_i);
        rx_hold_len = 0;
      end else if (rx_stall_en && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        // the edge at the top of the next loop pass also falls while ready is low
        repeat ($urandom_range(0, 18)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    update_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (update_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) begin
          $display("unexpected result transaction: error %0d drive %0d speed %0d",
                   speed_error_o, drive_value_o, new_speed_o);
        end
      end else begin
        want = update_q.pop_front();
        check_field("speed_error", want.err, speed_error_o);
        check_field("drive_value", want.drive, drive_value_o);
        check_field("new_speed", want.speed, new_speed_o);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CFG_PROP_GAIN;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    target_speed_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_gains();
    test_refused_writes();
    test_gain_extremes();
    test_random_settings();
    test_output_stall();
    test_full_rate();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && update_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pidsu_pkg.sv
rtl/pidsu_div.sv
rtl/pidsu_dpath.sv
rtl/pidsu_ctrl.sv
rtl/pid_speed_update.sv
bench/tb_top.sv
